// ===== src/cdp_pkg.sv =====
// ----------------------------------------------------------------------------
// Cookie date parser package
// Shared types and constants for the tokenizer and the epoch pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cdp_pkg;

  // Bit positions in the found mask, one per kind of token.
  localparam int unsigned FLAG_TIME  = 0;
  localparam int unsigned FLAG_DAY   = 1;
  localparam int unsigned FLAG_MONTH = 2;
  localparam int unsigned FLAG_YEAR  = 3;

  localparam logic [3:0] FLAG_ALL = 4'hF;

  // Fields collected from one date string.
  typedef struct packed {
    logic [3:0]  found;
    logic [20:0] hms;    // hour [6:0], minute [13:7], second [20:14]
    logic [6:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } cdp_fields_t;

endpackage

`default_nettype wire

// ===== src/cookie_date_parser.sv =====
// ----------------------------------------------------------------------------
// Cookie date parser
// Parses a cookie date string, one byte per transaction, and returns the
// date as signed seconds since 1970-01-01 UTC, or 0 when it cannot be parsed.
// ----------------------------------------------------------------------------
// Throughput: one byte per clock cycle while in_stall is low; strings may follow back to back.
// The result of a string is computed by a six-stage epoch pipeline, which takes
// the collected fields from the transaction that carries the last byte.
// Input stalls only when all six pipeline stages hold results and out_stall is high.
// Reset (synchronous, active low) clears the tokenizer, the collected fields
// and the pipeline valid bits.
`default_nettype none

module cookie_date_parser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_byte_value,
  input  wire logic               in_last,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [38:0]      out_epoch_seconds
);
  import cdp_pkg::*;

  localparam logic [13:0] PIVOT_LOW_MAX  = 14'd69;
  localparam logic [13:0] PIVOT_HIGH_MAX = 14'd99;
  localparam logic [13:0] CENTURY_2000   = 14'd2000;
  localparam logic [13:0] CENTURY_1900   = 14'd1900;
  localparam logic [13:0] YEAR_MIN       = 14'd1601;
  // Reciprocal of 100 scaled by 2^20; exact for every 14-bit dividend.
  localparam logic [13:0] RECIP_100      = 14'd10486;
  localparam logic [23:0] DAYS_TO_EPOCH  = 24'd719468;
  localparam logic signed [41:0] SECS_PER_DAY = 42'sd86400;

  // Days before the first of each month in a year that starts in March.
  function automatic logic [8:0] month_offset(input logic [3:0] mo);
    case (mo)
      4'd1:    month_offset = 9'd306;
      4'd2:    month_offset = 9'd337;
      4'd3:    month_offset = 9'd0;
      4'd4:    month_offset = 9'd31;
      4'd5:    month_offset = 9'd61;
      4'd6:    month_offset = 9'd92;
      4'd7:    month_offset = 9'd122;
      4'd8:    month_offset = 9'd153;
      4'd9:    month_offset = 9'd184;
      4'd10:   month_offset = 9'd214;
      4'd11:   month_offset = 9'd245;
      4'd12:   month_offset = 9'd275;
      default: month_offset = 9'd0;
    endcase
  endfunction

  logic        accept;
  logic        push;
  cdp_fields_t rec;

  logic [5:0]  st_valid_r;
  logic [5:0]  st_ready;

  assign accept   = in_valid & st_ready[0];
  assign in_stall = ~st_ready[0];

  cdp_tokenizer u_tokenizer (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .byte_value (in_byte_value),
    .last       (in_last),
    .push       (push),
    .rec        (rec)
  );

  // A stage takes new data when it is empty or its contents move on.
  always_comb begin
    st_ready[5] = ~st_valid_r[5] | ~out_stall;
    st_ready[4] = ~st_valid_r[4] | st_ready[5];
    st_ready[3] = ~st_valid_r[3] | st_ready[4];
    st_ready[2] = ~st_valid_r[2] | st_ready[3];
    st_ready[1] = ~st_valid_r[1] | st_ready[2];
    st_ready[0] = ~st_valid_r[0] | st_ready[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 6'd0;
    end else begin
      if (st_ready[0]) st_valid_r[0] <= push;
      if (st_ready[1]) st_valid_r[1] <= st_valid_r[0];
      if (st_ready[2]) st_valid_r[2] <= st_valid_r[1];
      if (st_ready[3]) st_valid_r[3] <= st_valid_r[2];
      if (st_ready[4]) st_valid_r[4] <= st_valid_r[3];
      if (st_ready[5]) st_valid_r[5] <= st_valid_r[4];
    end
  end

  // Stage 0: collected fields of a finished string.
  cdp_fields_t rec_r;

  always_ff @(posedge clk) begin
    if (st_ready[0] && push) begin
      rec_r <= rec;
    end
  end

  // Stage 1: year pivot, range checks, day of year and seconds of day.
  logic [6:0]  hh, mm, ss;
  logic [13:0] y_piv, y_adj;
  logic        ok_c;
  logic [8:0]  doy_c;
  logic [16:0] sod_c;
  logic        ok1_r;
  logic [13:0] y1_r;
  logic [8:0]  doy1_r;
  logic [16:0] sod1_r;

  always_comb begin
    hh = rec_r.hms[6:0];
    mm = rec_r.hms[13:7];
    ss = rec_r.hms[20:14];
    if (rec_r.year <= PIVOT_LOW_MAX) begin
      y_piv = rec_r.year + CENTURY_2000;
    end else if (rec_r.year <= PIVOT_HIGH_MAX) begin
      y_piv = rec_r.year + CENTURY_1900;
    end else begin
      y_piv = rec_r.year;
    end
    ok_c = (rec_r.found == FLAG_ALL) && (rec_r.day >= 7'd1) && (rec_r.day <= 7'd31) &&
           (y_piv >= YEAR_MIN) && (hh <= 7'd23) && (mm <= 7'd59) && (ss <= 7'd59) &&
           (rec_r.month >= 4'd1) && (rec_r.month <= 4'd12);
    // January and February count as the end of the previous year.
    y_adj = (rec_r.month <= 4'd2) ? y_piv - 14'd1 : y_piv;
    doy_c = month_offset(rec_r.month) + {2'd0, rec_r.day} - 9'd1;
    sod_c = 17'({10'd0, hh} * 17'd3600) + 17'({10'd0, mm} * 17'd60) + {10'd0, ss};
  end

  always_ff @(posedge clk) begin
    if (st_ready[1] && st_valid_r[0]) begin
      ok1_r  <= ok_c;
      y1_r   <= y_adj;
      doy1_r <= doy_c;
      sod1_r <= sod_c;
    end
  end

  // Stage 2: leap-year quotients and the days of whole years.
  logic [27:0] q100_prod;
  logic [25:0] q400_prod;
  logic [22:0] y365_c;
  logic        ok2_r;
  logic [22:0] y365_2_r;
  logic [11:0] q4_2_r;
  logic [7:0]  q100_2_r;
  logic [5:0]  q400_2_r;
  logic [8:0]  doy2_r;
  logic [16:0] sod2_r;

  always_comb begin
    q100_prod = {14'd0, y1_r} * {14'd0, RECIP_100};
    q400_prod = {14'd0, y1_r[13:2]} * {12'd0, RECIP_100};
    y365_c    = {9'd0, y1_r} * 23'd365;
  end

  always_ff @(posedge clk) begin
    if (st_ready[2] && st_valid_r[1]) begin
      ok2_r    <= ok1_r;
      y365_2_r <= y365_c;
      q4_2_r   <= y1_r[13:2];
      q100_2_r <= q100_prod[27:20];
      q400_2_r <= q400_prod[25:20];
      doy2_r   <= doy1_r;
      sod2_r   <= sod1_r;
    end
  end

  // Stage 3: days since the epoch.
  logic [23:0]        day_sum;
  logic signed [23:0] days_c;
  logic               ok3_r;
  logic signed [23:0] days3_r;
  logic [16:0]        sod3_r;

  always_comb begin
    day_sum = {1'b0, y365_2_r} + {12'd0, q4_2_r} + {18'd0, q400_2_r} + {15'd0, doy2_r} -
              {16'd0, q100_2_r};
    days_c  = $signed(day_sum - DAYS_TO_EPOCH);
  end

  always_ff @(posedge clk) begin
    if (st_ready[3] && st_valid_r[2]) begin
      ok3_r   <= ok2_r;
      days3_r <= days_c;
      sod3_r  <= sod2_r;
    end
  end

  // Stage 4: whole days in seconds.
  logic signed [41:0] day_secs;
  logic               ok4_r;
  logic signed [38:0] prod4_r;
  logic [16:0]        sod4_r;

  always_comb begin
    day_secs = $signed({{18{days3_r[23]}}, days3_r}) * SECS_PER_DAY;
  end

  always_ff @(posedge clk) begin
    if (st_ready[4] && st_valid_r[3]) begin
      ok4_r   <= ok3_r;
      prod4_r <= day_secs[38:0];
      sod4_r  <= sod3_r;
    end
  end

  // Stage 5: add the time of day; a true zero is reported as one.
  logic signed [38:0] secs_c;
  logic signed [38:0] epoch_c;
  logic signed [38:0] out_epoch_r;
  logic               out_ok_r;

  always_comb begin
    secs_c = prod4_r + $signed({22'd0, sod4_r});
    if (!ok4_r) begin
      epoch_c = 39'sd0;
    end else if (secs_c == 39'sd0) begin
      epoch_c = 39'sd1;
    end else begin
      epoch_c = secs_c;
    end
  end

  always_ff @(posedge clk) begin
    if (st_ready[5] && st_valid_r[4]) begin
      out_epoch_r <= epoch_c;
      out_ok_r    <= ok4_r;
    end
  end

  assign out_valid         = st_valid_r[5];
  assign out_epoch_seconds = out_epoch_r;

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (st_valid_r == 6'h3F))
    else $error("input stalled while the pipeline has room");

  a_last_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last) |=> st_valid_r[0])
    else $error("last byte did not start a pipeline transaction");

  a_zero_means_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_epoch_seconds != 39'sd0) == out_ok_r))
    else $error("result zero does not match the validity check");

endmodule

`default_nettype wire

// ===== src/cdp_tokenizer.sv =====
// ----------------------------------------------------------------------------
// Cookie date tokenizer
// Splits the byte stream into tokens, runs the time, day, month and year
// recognizers on every byte of a token and takes each kind of field once.
// ----------------------------------------------------------------------------
`default_nettype none

module cdp_tokenizer (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire logic [7:0]         byte_value,
  input  wire logic               last,
  output logic                    push,
  output cdp_pkg::cdp_fields_t    rec
);
  import cdp_pkg::*;

  localparam logic [2:0] TP_HOUR  = 3'd0;
  localparam logic [2:0] TP_MIN   = 3'd1;
  localparam logic [2:0] TP_SEC   = 3'd2;
  localparam logic [2:0] TP_MATCH = 3'd3;
  localparam logic [2:0] TP_FAIL  = 3'd4;

  localparam logic [2:0] DR_INVALID  = 3'd0;
  localparam logic [2:0] DR_OPEN1    = 3'd1;
  localparam logic [2:0] DR_OPEN2    = 3'd2;
  localparam logic [2:0] DR_OPEN3    = 3'd3;
  localparam logic [2:0] DR_OPEN4    = 3'd4;
  localparam logic [2:0] DR_CLOSED1  = 3'd5;
  localparam logic [2:0] DR_CLOSED2  = 3'd6;
  localparam logic [2:0] DR_CLOSED34 = 3'd7;

  localparam logic [7:0] CHAR_COLON = 8'h3A;

  // First three letters of each month name as {third, second, first} codes.
  localparam logic [11:0][14:0] MONTH_CODES = {
    {5'd3,  5'd5,  5'd4},   // dec
    {5'd22, 5'd15, 5'd14},  // nov
    {5'd20, 5'd3,  5'd15},  // oct
    {5'd16, 5'd5,  5'd19},  // sep
    {5'd7,  5'd21, 5'd1},   // aug
    {5'd12, 5'd21, 5'd10},  // jul
    {5'd14, 5'd21, 5'd10},  // jun
    {5'd25, 5'd1,  5'd13},  // may
    {5'd18, 5'd16, 5'd1},   // apr
    {5'd18, 5'd1,  5'd13},  // mar
    {5'd2,  5'd5,  5'd6},   // feb
    {5'd14, 5'd1,  5'd10}   // jan
  };

  function automatic logic delim_char(input logic [7:0] c);
    delim_char = (c == 8'h00) || (c == 8'h09) ||
                 (c >= 8'h20 && c <= 8'h2F) || (c >= 8'h3B && c <= 8'h40) ||
                 (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
  endfunction

  function automatic logic [4:0] letter_code(input logic [7:0] c);
    logic [7:0] diff;
    diff = 8'h00;
    if (c >= 8'h61 && c <= 8'h7A) begin
      diff = c - 8'h60;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      diff = c - 8'h40;
    end
    letter_code = diff[4:0];
  endfunction

  // Token state
  logic        in_token_r, in_token_nxt;
  logic [1:0]  tcs_r, tcs_nxt;
  logic [15:0] fl_r, fl_nxt;
  logic [2:0]  drl_r, drl_nxt;
  logic [13:0] drv_r, drv_nxt;
  logic [2:0]  tp_r, tp_nxt;
  logic [1:0]  tdc_r, tdc_nxt;
  logic [20:0] tc_r, tc_nxt;
  cdp_fields_t fields_r, fields_nxt;

  // Token state after this byte has been fed
  logic        in_tok_f;
  logic [1:0]  tcs_f;
  logic [15:0] fl_f;
  logic [2:0]  drl_f;
  logic [13:0] drv_f;
  logic [2:0]  tp_f;
  logic [1:0]  tdc_f;
  logic [20:0] tc_f;

  logic        delim;
  logic        digit_hit;
  logic [3:0]  digit;
  logic [4:0]  code;
  logic        finish;
  logic        month_hit;
  logic [3:0]  month_idx;
  logic        time_ok, day_ok, year_ok;
  cdp_fields_t fields_f;

  always_comb begin
    delim     = delim_char(byte_value);
    digit_hit = (byte_value >= 8'h30) && (byte_value <= 8'h39);
    digit     = digit_hit ? 4'(byte_value - 8'h30) : 4'd0;
    code      = letter_code(byte_value);

    tcs_f = tcs_r;
    fl_f  = fl_r;
    drl_f = drl_r;
    drv_f = drv_r;
    tp_f  = tp_r;
    tdc_f = tdc_r;
    tc_f  = tc_r;

    if (!delim) begin
      case (tcs_r)
        2'd0: fl_f[4:0]   = fl_r[4:0] | code;
        2'd1: fl_f[9:5]   = fl_r[9:5] | code;
        2'd2: fl_f[14:10] = fl_r[14:10] | code;
        default: ;
      endcase
      if (tcs_r != 2'd3) begin
        tcs_f = tcs_r + 2'd1;
      end

      // Leading digit run of the token.
      if (tcs_r == 2'd0) begin
        drl_f = digit_hit ? DR_OPEN1 : DR_INVALID;
        drv_f = {10'd0, digit};
      end else if (drl_r >= DR_OPEN1 && drl_r <= DR_OPEN4) begin
        if (digit_hit) begin
          if (drl_r == DR_OPEN4) begin
            drl_f = DR_INVALID;
          end else begin
            drv_f = 14'(drv_r * 14'd10 + {10'd0, digit});
            drl_f = drl_r + 3'd1;
          end
        end else begin
          case (drl_r)
            DR_OPEN1: drl_f = DR_CLOSED1;
            DR_OPEN2: drl_f = DR_CLOSED2;
            default:  drl_f = DR_CLOSED34;
          endcase
        end
      end

      // Time recognizer: h:m:s with one or two digits per field.
      if (tp_r <= TP_SEC) begin
        if (digit_hit) begin
          if (tdc_r < 2'd2) begin
            case (tp_r)
              TP_HOUR: tc_f[6:0]   = 7'(tc_r[6:0] * 7'd10 + {3'd0, digit});
              TP_MIN:  tc_f[13:7]  = 7'(tc_r[13:7] * 7'd10 + {3'd0, digit});
              default: tc_f[20:14] = 7'(tc_r[20:14] * 7'd10 + {3'd0, digit});
            endcase
            tdc_f = tdc_r + 2'd1;
          end else begin
            tp_f = TP_FAIL;
          end
        end else if (tdc_r == 2'd0) begin
          tp_f = TP_FAIL;
        end else if (tp_r < TP_SEC) begin
          if (byte_value == CHAR_COLON) begin
            tp_f  = tp_r + 3'd1;
            tdc_f = 2'd0;
          end else begin
            tp_f = TP_FAIL;
          end
        end else begin
          tp_f = TP_MATCH;
        end
      end
    end

    in_tok_f = in_token_r | !delim;
    finish   = in_tok_f & (delim | last);

    month_hit = 1'b0;
    month_idx = 4'd0;
    for (int k = 0; k < 12; k++) begin
      if (fl_f[14:0] == MONTH_CODES[k]) begin
        month_hit = 1'b1;
        month_idx = 4'(k + 1);
      end
    end

    time_ok = (tp_f == TP_MATCH) || ((tp_f == TP_SEC) && (tdc_f != 2'd0));
    day_ok  = (drl_f == DR_OPEN1) || (drl_f == DR_OPEN2) ||
              (drl_f == DR_CLOSED1) || (drl_f == DR_CLOSED2);
    year_ok = (drl_f == DR_OPEN2) || (drl_f == DR_OPEN3) || (drl_f == DR_OPEN4) ||
              (drl_f == DR_CLOSED2) || (drl_f == DR_CLOSED34);

    // A finished token fills the first kind that it matches and is still free.
    fields_f = fields_r;
    if (finish) begin
      if (!fields_r.found[FLAG_TIME] && time_ok) begin
        fields_f.found[FLAG_TIME] = 1'b1;
        fields_f.hms = tc_f;
      end else if (!fields_r.found[FLAG_DAY] && day_ok) begin
        fields_f.found[FLAG_DAY] = 1'b1;
        fields_f.day = drv_f[6:0];
      end else if (!fields_r.found[FLAG_MONTH] && (tcs_f == 2'd3) && month_hit) begin
        fields_f.found[FLAG_MONTH] = 1'b1;
        fields_f.month = month_idx;
      end else if (!fields_r.found[FLAG_YEAR] && year_ok) begin
        fields_f.found[FLAG_YEAR] = 1'b1;
        fields_f.year = drv_f;
      end
    end

    in_token_nxt = in_token_r;
    tcs_nxt      = tcs_r;
    fl_nxt       = fl_r;
    drl_nxt      = drl_r;
    drv_nxt      = drv_r;
    tp_nxt       = tp_r;
    tdc_nxt      = tdc_r;
    tc_nxt       = tc_r;
    fields_nxt   = fields_r;

    if (accept) begin
      if (finish || last) begin
        in_token_nxt = 1'b0;
        tcs_nxt      = 2'd0;
        fl_nxt       = 16'd0;
        drl_nxt      = DR_INVALID;
        drv_nxt      = 14'd0;
        tp_nxt       = TP_HOUR;
        tdc_nxt      = 2'd0;
        tc_nxt       = 21'd0;
      end else begin
        in_token_nxt = in_tok_f;
        tcs_nxt      = tcs_f;
        fl_nxt       = fl_f;
        drl_nxt      = drl_f;
        drv_nxt      = drv_f;
        tp_nxt       = tp_f;
        tdc_nxt      = tdc_f;
        tc_nxt       = tc_f;
      end
      fields_nxt = last ? '0 : fields_f;
    end
  end

  assign push = accept & last;
  assign rec  = fields_f;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_token_r <= 1'b0;
      tcs_r      <= 2'd0;
      fl_r       <= 16'd0;
      drl_r      <= DR_INVALID;
      drv_r      <= 14'd0;
      tp_r       <= TP_HOUR;
      tdc_r      <= 2'd0;
      tc_r       <= 21'd0;
      fields_r   <= '0;
    end else begin
      in_token_r <= in_token_nxt;
      tcs_r      <= tcs_nxt;
      fl_r       <= fl_nxt;
      drl_r      <= drl_nxt;
      drv_r      <= drv_nxt;
      tp_r       <= tp_nxt;
      tdc_r      <= tdc_nxt;
      tc_r       <= tc_nxt;
      fields_r   <= fields_nxt;
    end
  end

  // Outside a token the recognizers sit at their cleared values.
  a_idle_token_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !in_token_r |-> (tcs_r == 2'd0 && drl_r == DR_INVALID && tp_r == TP_HOUR &&
                     tdc_r == 2'd0 && tc_r == 21'd0 && fl_r == 16'd0))
    else $error("token state not clear outside a token");

  a_time_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    tp_r <= TP_FAIL)
    else $error("time phase out of range");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (fields_r.found == 4'd0 && !in_token_r))
    else $error("fields not cleared after the last byte");

endmodule

`default_nettype wire
